/* rtl/core/rle8_line_decoder_assert.svh */
// ----------------------------------------------------------------------------
// RLE8 line decoder assertion macros
// Property wrappers used by the port checker of the line decoder.
// ----------------------------------------------------------------------------
`ifndef RLE8_LINE_DECODER_ASSERT_SVH
`define RLE8_LINE_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RLE8D_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RLE8D_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rle8d_pkg.sv */
// ----------------------------------------------------------------------------
// RLE8 line decoder package
// Widths, command codes, parser phases and item structures.
// ----------------------------------------------------------------------------
package rle8d_pkg;

    localparam int POS_W = 13;
    localparam int ROW_W = 12;
    localparam int CFG_W = 13;
    localparam int CFG_IDX_W = 1;

    // Widest line the decoder honors; a larger line_width is clamped to it.
    localparam logic [POS_W-1:0] MAX_LINE_WIDTH = 13'd4096;
    localparam logic [POS_W-1:0] POS_MAX = 13'h1FFF;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [7:0] CODE_SKIP  = 8'd0;
    localparam logic [7:0] CODE_FILL  = 8'd1;
    localparam logic [7:0] CODE_LIT_A = 8'd2;
    localparam logic [7:0] CODE_LIT_B = 8'd4;

    localparam logic [1:0] KIND_SKIP = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_LIT  = 2'd2;

    localparam logic [7:0] LIT_LEN = 8'd1;

    typedef enum logic [2:0] {
        PH_CODE,
        PH_SKIP_COUNT,
        PH_FILL_COUNT,
        PH_FILL_COLOR,
        PH_LIT_COUNT,
        PH_LIT_DATA
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_start;
        logic       image_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       run_kind;
        logic [POS_W-1:0] x_start;
        logic [7:0]       run_length;
        logic [7:0]       pixel_value;
        logic [ROW_W-1:0] row_index;
        logic             end_of_line;
        logic             end_of_image;
    } t_out_item;

    // Handshake between the input register and the rest of the pipe.
    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage

/* rtl/core/rle8d_if.sv */
// ----------------------------------------------------------------------------
// RLE8 line decoder channels
// Valid/ready channels for coded bytes in and decoded runs out.
// ----------------------------------------------------------------------------
interface rle8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       line_start;
    logic       image_start;

    modport source (output valid, output data_byte, output line_start,
                    output image_start, input ready);
    modport sink (input valid, input data_byte, input line_start,
                  input image_start, output ready);
endinterface

interface rle8d_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 run_kind;
    logic [rle8d_pkg::POS_W-1:0] x_start;
    logic [7:0]                 run_length;
    logic [7:0]                 pixel_value;
    logic [rle8d_pkg::ROW_W-1:0] row_index;
    logic                       end_of_line;
    logic                       end_of_image;

    modport source (output valid, output run_kind, output x_start,
                    output run_length, output pixel_value, output row_index,
                    output end_of_line, output end_of_image, input ready);
    modport sink (input valid, input run_kind, input x_start,
                  input run_length, input pixel_value, input row_index,
                  input end_of_line, input end_of_image, output ready);
endinterface

/* rtl/core/rle8d_in_reg.sv */
// ----------------------------------------------------------------------------
// RLE8 line decoder input register
// Captures each accepted byte and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module rle8d_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rle8d_in_if.sink            i_in,
    input  logic                i_advance,
    output logic                o_valid,
    output rle8d_pkg::t_in_item o_item
);

    logic                r_valid;
    rle8d_pkg::t_in_item r_item;

    assign i_in.ready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.data_byte   <= i_in.data_byte;
            r_item.line_start  <= i_in.line_start;
            r_item.image_start <= i_in.image_start;
        end
    end

endmodule

/* rtl/core/rle8d_parser.sv */
// ----------------------------------------------------------------------------
// RLE8 line decoder parser
// Command state, position and row tracking, and result formation per byte.
// ----------------------------------------------------------------------------
module rle8d_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  rle8d_pkg::t_in_item                 i_item,
    input  logic                                i_cfg_we,
    input  logic [rle8d_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rle8d_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                                o_res_valid,
    output rle8d_pkg::t_out_item                o_res
);

    localparam int POS_W = rle8d_pkg::POS_W;
    localparam int ROW_W = rle8d_pkg::ROW_W;

    logic [rle8d_pkg::CFG_W-1:0] r_line_width;
    logic [rle8d_pkg::CFG_W-1:0] r_image_height;
    rle8d_pkg::t_phase           r_phase, n_phase;
    logic [POS_W-1:0]            r_pos, n_pos;
    logic [7:0]                  r_run, n_run;
    logic [7:0]                  r_lit, n_lit;
    logic [ROW_W-1:0]            r_row, n_row;
    logic                        r_fin, n_fin;

    // State as seen by this byte, after any line or image restart.
    logic                        restart;
    rle8d_pkg::t_phase           e_phase;
    logic [POS_W-1:0]            e_pos;
    logic [7:0]                  e_run;
    logic [7:0]                  e_lit;
    logic [ROW_W-1:0]            e_row;
    logic                        e_fin;

    logic [POS_W-1:0]            width;
    logic [7:0]                  cnt;
    logic [POS_W:0]              sum;
    logic [POS_W-1:0]            sat;
    logic                        pos_ge_w;
    logic                        new_ge_w;
    logic                        eol;
    logic [ROW_W-1:0]            row_inc;
    logic [rle8d_pkg::CFG_W-1:0] row_num;
    logic [7:0]                  lit_dec;
    logic                        finish;
    logic                        res_valid;
    logic [1:0]                  kind;
    logic [7:0]                  len;
    logic [7:0]                  val;
    logic [7:0]                  b;

    assign b       = i_item.data_byte;
    assign restart = i_item.line_start || i_item.image_start;
    assign e_phase = restart ? rle8d_pkg::PH_CODE : r_phase;
    assign e_pos   = restart ? '0 : r_pos;
    assign e_run   = restart ? '0 : r_run;
    assign e_lit   = restart ? '0 : r_lit;
    assign e_fin   = restart ? 1'b0 : r_fin;
    assign e_row   = i_item.image_start ? '0 : r_row;

    assign width = (r_line_width > rle8d_pkg::MAX_LINE_WIDTH) ?
                   rle8d_pkg::MAX_LINE_WIDTH : r_line_width;

    always_comb begin
        case (e_phase)
            rle8d_pkg::PH_SKIP_COUNT: cnt = b;
            rle8d_pkg::PH_FILL_COLOR: cnt = e_run;
            rle8d_pkg::PH_LIT_DATA:   cnt = rle8d_pkg::LIT_LEN;
            default:                  cnt = '0;
        endcase
    end

    // The position saturates instead of wrapping.
    assign sum      = {1'b0, e_pos} + {{(POS_W-7){1'b0}}, cnt};
    assign sat      = sum[POS_W] ? rle8d_pkg::POS_MAX : sum[POS_W-1:0];
    assign pos_ge_w = (e_pos >= width);
    assign new_ge_w = (sat >= width);
    assign eol      = !pos_ge_w && new_ge_w;
    assign row_inc  = e_row + 1'b1;
    assign row_num  = {1'b0, e_row} + 1'b1;
    assign lit_dec  = e_lit - 1'b1;

    always_comb begin
        n_phase   = e_phase;
        n_pos     = e_pos;
        n_run     = e_run;
        n_lit     = e_lit;
        n_row     = e_row;
        n_fin     = e_fin;
        finish    = 1'b0;
        res_valid = 1'b0;
        kind      = rle8d_pkg::KIND_SKIP;
        len       = '0;
        val       = '0;
        if (!e_fin) begin
            case (e_phase)
                rle8d_pkg::PH_CODE: begin
                    // A code byte arriving with the line already full closes it.
                    if (pos_ge_w) begin
                        n_fin = 1'b1;
                        n_row = row_inc;
                    end else if (b == rle8d_pkg::CODE_SKIP) begin
                        n_phase = rle8d_pkg::PH_SKIP_COUNT;
                    end else if (b == rle8d_pkg::CODE_FILL) begin
                        n_phase = rle8d_pkg::PH_FILL_COUNT;
                    end else if (b == rle8d_pkg::CODE_LIT_A ||
                                 b == rle8d_pkg::CODE_LIT_B) begin
                        n_phase = rle8d_pkg::PH_LIT_COUNT;
                    end
                end
                rle8d_pkg::PH_SKIP_COUNT: begin
                    res_valid = 1'b1;
                    kind      = rle8d_pkg::KIND_SKIP;
                    len       = b;
                    n_pos     = sat;
                    finish    = 1'b1;
                end
                rle8d_pkg::PH_FILL_COUNT: begin
                    n_run   = b;
                    n_phase = rle8d_pkg::PH_FILL_COLOR;
                end
                rle8d_pkg::PH_FILL_COLOR: begin
                    res_valid = 1'b1;
                    kind      = rle8d_pkg::KIND_FILL;
                    len       = e_run;
                    val       = b;
                    n_pos     = sat;
                    finish    = 1'b1;
                end
                rle8d_pkg::PH_LIT_COUNT: begin
                    n_lit = b;
                    if (b == '0) begin
                        finish = 1'b1;
                    end else begin
                        n_phase = rle8d_pkg::PH_LIT_DATA;
                    end
                end
                rle8d_pkg::PH_LIT_DATA: begin
                    res_valid = 1'b1;
                    kind      = rle8d_pkg::KIND_LIT;
                    len       = rle8d_pkg::LIT_LEN;
                    val       = b;
                    n_pos     = sat;
                    n_lit     = lit_dec;
                    finish    = (lit_dec == '0);
                end
                default: begin
                    n_phase = rle8d_pkg::PH_CODE;
                end
            endcase
        end
        if (finish) begin
            n_phase = rle8d_pkg::PH_CODE;
            if (new_ge_w) begin
                n_fin = 1'b1;
                n_row = row_inc;
            end
        end
    end

    assign o_res_valid        = res_valid;
    assign o_res.run_kind     = kind;
    assign o_res.x_start      = e_pos;
    assign o_res.run_length   = len;
    assign o_res.pixel_value  = val;
    assign o_res.row_index    = e_row;
    assign o_res.end_of_line  = eol;
    assign o_res.end_of_image = eol && (row_num == r_image_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rle8d_pkg::PH_CODE;
            r_pos   <= '0;
            r_run   <= '0;
            r_lit   <= '0;
            r_row   <= '0;
            r_fin   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_run   <= n_run;
            r_lit   <= n_lit;
            r_row   <= n_row;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= 13'd1;
            r_image_height <= 13'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rle8d_pkg::REG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                rle8d_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/core/rle8d_out_reg.sv */
// ----------------------------------------------------------------------------
// RLE8 line decoder output register
// Holds one decoded result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rle8d_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_res_valid,
    input  rle8d_pkg::t_out_item i_res,
    output logic                 o_full,
    rle8d_out_if.source          o_out
);

    logic                 r_valid;
    rle8d_pkg::t_out_item r_res;

    assign o_full             = r_valid;
    assign o_out.valid        = r_valid;
    assign o_out.run_kind     = r_res.run_kind;
    assign o_out.x_start      = r_res.x_start;
    assign o_out.run_length   = r_res.run_length;
    assign o_out.pixel_value  = r_res.pixel_value;
    assign o_out.row_index    = r_res.row_index;
    assign o_out.end_of_line  = r_res.end_of_line;
    assign o_out.end_of_image = r_res.end_of_image;

    // A load only happens when the register is empty or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

/* rtl/core/rle8_line_decoder.sv */
// ----------------------------------------------------------------------------
// RLE8 line decoder
// Byte-serial decoder of run-length coded 8-bit scanlines into run results.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | handshake
//  --------+-----+------------------------------------------------+----------
//  i_in    | in  | data_byte, line_start, image_start             | valid/ready
//  o_out   | out | run_kind, x_start, run_length, pixel_value,    | valid/ready
//          |     | row_index, end_of_line, end_of_image           |
//  i_cfg_* | in  | i_cfg_idx, i_cfg_data                          | i_cfg_we
//
// One byte per clock while the output is not stalled: a byte is held in the input
// register, and its result, if any, is loaded into the output register when the parser steps.
// The throughput is set by the single parser step between these two registers.
// Reset (i_rst_n low, synchronous) empties both registers, restarts row 0 and
// sets line_width and image_height to 1.
// A stalled output holds its transaction; the input keeps taking bytes until
// the input register is also occupied.
module rle8_line_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rle8d_in_if.sink                        i_in,
    rle8d_out_if.source                     o_out,
    input  logic                            i_cfg_we,
    input  logic [rle8d_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rle8d_pkg::CFG_W-1:0]     i_cfg_data
);

    rle8d_pkg::t_stage_ctl stage;
    rle8d_pkg::t_in_item   item;
    rle8d_pkg::t_out_item  res;
    logic                  res_valid;
    logic                  out_full;

    assign stage.advance = stage.valid && (!out_full || o_out.ready);

    rle8d_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (stage.advance),
        .o_valid   (stage.valid),
        .o_item    (item)
    );

    rle8d_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (stage.advance),
        .i_item      (item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rle8d_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (stage.advance),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_full      (out_full),
        .o_out       (o_out)
    );

endmodule

/* rtl/core/rle8d_checker.sv */
// ----------------------------------------------------------------------------
// RLE8 line decoder port checker
// Checks result transactions seen on the decoder's output port.
// ----------------------------------------------------------------------------
`include "rle8_line_decoder_assert.svh"

module rle8d_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_ready,
    input logic [1:0]                  i_run_kind,
    input logic [rle8d_pkg::POS_W-1:0] i_x_start,
    input logic [7:0]                  i_run_length,
    input logic [7:0]                  i_pixel_value,
    input logic [rle8d_pkg::ROW_W-1:0] i_row_index,
    input logic                        i_end_of_line,
    input logic                        i_end_of_image
);

    `RLE8D_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_run_kind) && $stable(i_x_start) && $stable(i_run_length) && $stable(i_pixel_value) && $stable(i_row_index) && $stable(i_end_of_line) && $stable(i_end_of_image), "stalled result changed")
    `RLE8D_ASSERT_IMP(a_eoi_eol, i_clk, i_rst_n, i_valid && i_end_of_image, i_end_of_line, "image end without line end")
    `RLE8D_ASSERT_IMP(a_lit_len, i_clk, i_rst_n, i_valid && i_run_kind == rle8d_pkg::KIND_LIT, i_run_length == 8'd1, "literal pixel length is not one")
    `RLE8D_ASSERT_IMP(a_eol_len, i_clk, i_rst_n, i_valid && i_end_of_line, i_run_length != 8'd0, "line end from an empty run")
    `RLE8D_ASSERT_IMP(a_rst_empty, i_clk, i_rst_n, $past(!i_rst_n), !i_valid, "result present right after reset")

endmodule

bind rle8_line_decoder rle8d_checker u_rle8d_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_run_kind     (o_out.run_kind),
    .i_x_start      (o_out.x_start),
    .i_run_length   (o_out.run_length),
    .i_pixel_value  (o_out.pixel_value),
    .i_row_index    (o_out.row_index),
    .i_end_of_line  (o_out.end_of_line),
    .i_end_of_image (o_out.end_of_image)
);
